// File: src/qsj_pkg.sv
`default_nettype none
package qsj_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int RESULT_FRAC_BITS_DEF = 14;
    localparam int QUALITY_W            = 16;
    localparam int NUM_CORNERS          = 4;
    localparam int NUM_AXES             = 3;

    // Per corner: u head, u tail, v head, v tail
    localparam int EDGE_TAB [NUM_CORNERS][4] = '{
        '{1, 0, 3, 0},
        '{1, 0, 2, 1},
        '{2, 3, 2, 1},
        '{2, 3, 3, 0}
    };

endpackage
`default_nettype wire

// File: src/quad_scaled_jacobian.sv
`default_nettype none
// Scaled Jacobian quality of one quadrilateral.
// Input channel (in_valid/in_ready): twelve corner coordinates, one quad per transfer.
// Output channel (out_valid/out_ready): quality in Q2.14, minimum over the four corners.
// Config channel (cfg_valid/cfg_ready): cfg_data bit 0 sets clamp_enable; always ready.
// Each corner runs in its own lane: edge vectors, squared lengths and determinant,
// split wide products, then a root stage per result bit (RESULT_FRAC_BITS + 1 stages).
// A merge stage takes the minimum, applies clamp and 16-bit saturation.
// Throughput: one quad per cycle while out_ready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears all valid flags and clamp_enable; no result is shown after reset
// until an input transfer reaches the end of the pipe.
module quad_scaled_jacobian #(
    parameter int COORD_BITS       = qsj_pkg::COORD_BITS_DEF,
    parameter int RESULT_FRAC_BITS = qsj_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [COORD_BITS-1:0]        corner0_x,
    input  wire logic signed [COORD_BITS-1:0]        corner0_y,
    input  wire logic signed [COORD_BITS-1:0]        corner0_z,
    input  wire logic signed [COORD_BITS-1:0]        corner1_x,
    input  wire logic signed [COORD_BITS-1:0]        corner1_y,
    input  wire logic signed [COORD_BITS-1:0]        corner1_z,
    input  wire logic signed [COORD_BITS-1:0]        corner2_x,
    input  wire logic signed [COORD_BITS-1:0]        corner2_y,
    input  wire logic signed [COORD_BITS-1:0]        corner2_z,
    input  wire logic signed [COORD_BITS-1:0]        corner3_x,
    input  wire logic signed [COORD_BITS-1:0]        corner3_y,
    input  wire logic signed [COORD_BITS-1:0]        corner3_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [qsj_pkg::QUALITY_W-1:0]     quality
);
    import qsj_pkg::*;

    localparam int LAT = RESULT_FRAC_BITS + 7;
    localparam int QW  = RESULT_FRAC_BITS + 2;

    logic                          clamp_enable_reg;
    logic [LAT-1:0]                vld_reg;
    logic                          en;
    logic signed [COORD_BITS-1:0]  pts [NUM_CORNERS][NUM_AXES];
    logic signed [QW-1:0]          q [NUM_CORNERS];

    assign pts[0] = '{corner0_x, corner0_y, corner0_z};
    assign pts[1] = '{corner1_x, corner1_y, corner1_z};
    assign pts[2] = '{corner2_x, corner2_y, corner2_z};
    assign pts[3] = '{corner3_x, corner3_y, corner3_z};

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_enable_reg <= 1'b0;
            vld_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
                clamp_enable_reg <= cfg_data;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    for (genvar c = 0; c < NUM_CORNERS; c++)
    begin : g_lane
        qsj_lane #(
            .COORD_BITS       (COORD_BITS),
            .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .uh  (pts[EDGE_TAB[c][0]]),
            .ut  (pts[EDGE_TAB[c][1]]),
            .vh  (pts[EDGE_TAB[c][2]]),
            .vt  (pts[EDGE_TAB[c][3]]),
            .q   (q[c])
        );
    end

    qsj_min #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_min (
        .clk         (clk),
        .en          (en),
        .clamp       (clamp_enable_reg),
        .q           (q),
        .quality_reg (quality)
    );

endmodule
`default_nettype wire

// File: src/qsj_lane.sv
`default_nettype none
module qsj_lane #(
    parameter int COORD_BITS       = qsj_pkg::COORD_BITS_DEF,
    parameter int RESULT_FRAC_BITS = qsj_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [COORD_BITS-1:0]  uh [qsj_pkg::NUM_AXES],
    input  wire logic signed [COORD_BITS-1:0]  ut [qsj_pkg::NUM_AXES],
    input  wire logic signed [COORD_BITS-1:0]  vh [qsj_pkg::NUM_AXES],
    input  wire logic signed [COORD_BITS-1:0]  vt [qsj_pkg::NUM_AXES],
    output logic signed [RESULT_FRAC_BITS+1:0] q
);
    import qsj_pkg::*;

    localparam int F    = RESULT_FRAC_BITS;
    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int LW   = SQW + 2;
    localparam int DETW = 2 * DW + 1;
    localparam int ADW  = 2 * DW;
    localparam int PW   = 2 * LW;
    localparam int MW   = F + 1;
    localparam int RW   = PW + MW + F + 2;
    localparam int H    = LW / 2;
    localparam int HA   = ADW / 2;
    localparam int QW   = F + 2;

    logic signed [DW-1:0]     du_reg [NUM_AXES];
    logic signed [DW-1:0]     dv_reg [NUM_AXES];
    logic signed [SQW-1:0]    squ_reg [NUM_AXES];
    logic signed [SQW-1:0]    sqv_reg [NUM_AXES];
    logic signed [SQW-1:0]    p0_reg;
    logic signed [SQW-1:0]    p1_reg;
    logic [LW-1:0]            lu_reg;
    logic [LW-1:0]            lv_reg;
    logic signed [DETW-1:0]   det_reg;
    logic [LW-H+LW-1:0]       lph_reg;
    logic [H+LW-1:0]          lpl_reg;
    logic [ADW-HA+ADW-1:0]    dph_reg;
    logic [HA+ADW-1:0]        dpl_reg;
    logic                     neg4_reg;
    logic                     zero4_reg;
    logic [ADW-1:0]           absdet;

    logic [RW-1:0]            r_reg  [F+2];
    logic [RW-1:0]            ml_reg [F+2];
    logic [PW-1:0]            l_reg  [F+2];
    logic [MW-1:0]            m_reg  [F+2];
    logic                     neg_reg  [F+2];
    logic                     zero_reg [F+2];

    assign absdet = det_reg[DETW-1] ? ADW'(-det_reg) : ADW'(det_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                du_reg[k]  <= DW'(uh[k]) - DW'(ut[k]);
                dv_reg[k]  <= DW'(vh[k]) - DW'(vt[k]);
                squ_reg[k] <= SQW'(du_reg[k]) * SQW'(du_reg[k]);
                sqv_reg[k] <= SQW'(dv_reg[k]) * SQW'(dv_reg[k]);
            end
            p0_reg <= SQW'(du_reg[0]) * SQW'(dv_reg[1]);
            p1_reg <= SQW'(dv_reg[0]) * SQW'(du_reg[1]);

            lu_reg  <= LW'(squ_reg[0]) + LW'(squ_reg[1]) + LW'(squ_reg[2]);
            lv_reg  <= LW'(sqv_reg[0]) + LW'(sqv_reg[1]) + LW'(sqv_reg[2]);
            det_reg <= DETW'(p0_reg) - DETW'(p1_reg);

            lph_reg   <= lu_reg[LW-1:H] * lv_reg;
            lpl_reg   <= lu_reg[H-1:0] * lv_reg;
            dph_reg   <= absdet[ADW-1:HA] * absdet;
            dpl_reg   <= absdet[HA-1:0] * absdet;
            neg4_reg  <= det_reg[DETW-1];
            zero4_reg <= (lu_reg == '0) || (lv_reg == '0);

            l_reg[0]    <= (PW'(lph_reg) << H) + PW'(lpl_reg);
            r_reg[0]    <= ((RW'(dph_reg) << HA) + RW'(dpl_reg)) << (2 * F);
            ml_reg[0]   <= '0;
            m_reg[0]    <= '0;
            neg_reg[0]  <= neg4_reg;
            zero_reg[0] <= zero4_reg;
        end
    end

    // One result bit per stage, MSB first; residual kept as D - m^2*L
    for (genvar i = 0; i <= F; i++)
    begin : g_root
        localparam int B = F - i;
        logic [RW-1:0] t;
        logic          take;

        assign t    = (ml_reg[i] << (B + 1)) + (RW'(l_reg[i]) << (2 * B));
        assign take = (t <= r_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]    <= take ? r_reg[i] - t : r_reg[i];
                ml_reg[i+1]   <= take ? ml_reg[i] + (RW'(l_reg[i]) << B) : ml_reg[i];
                m_reg[i+1]    <= take ? (m_reg[i] | (MW'(1) << B)) : m_reg[i];
                l_reg[i+1]    <= l_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[F+1])
            q = '0;
        else if (neg_reg[F+1])
            q = -QW'(m_reg[F+1]);
        else
            q = QW'(m_reg[F+1]);
    end

endmodule
`default_nettype wire

// File: src/qsj_min.sv
`default_nettype none
module qsj_min #(
    parameter int RESULT_FRAC_BITS = qsj_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic                                  clamp,
    input  wire logic signed [RESULT_FRAC_BITS+1:0]    q [qsj_pkg::NUM_CORNERS],
    output logic signed [qsj_pkg::QUALITY_W-1:0]       quality_reg
);
    import qsj_pkg::*;

    localparam int QW = RESULT_FRAC_BITS + 2;

    logic signed [QW-1:0] m01;
    logic signed [QW-1:0] m23;
    logic signed [QW-1:0] mall;
    logic signed [31:0]   w;
    logic signed [31:0]   c;
    logic signed [31:0]   one;
    logic signed [QUALITY_W-1:0] quality_next;

    assign one  = 32'sd1 <<< RESULT_FRAC_BITS;
    assign m01  = (q[1] < q[0]) ? q[1] : q[0];
    assign m23  = (q[3] < q[2]) ? q[3] : q[2];
    assign mall = (m23 < m01) ? m23 : m01;
    assign w    = 32'(mall);

    always_comb
    begin
        c = w;
        if (clamp)
        begin
            if (c > one)
                c = one;
            if (c < -one)
                c = -one;
        end
        if (c > 32'sd32767)
            quality_next = 16'sh7fff;
        else if (c < -32'sd32768)
            quality_next = 16'sh8000;
        else
            quality_next = c[QUALITY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quality_reg <= quality_next;
    end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
    import qsj_pkg::*;

    typedef logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_BITS_DEF-1:0] quad_t;

    localparam int LATENCY = RESULT_FRAC_BITS_DEF + 7;
    localparam logic [15:0] CMAX = 16'h7fff;
    localparam logic [15:0] CMIN = 16'h8000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [QUALITY_W-1:0] quality;
    quad_t quad_drv = '0;

    quad_t pending_quads[$];
    logic signed [QUALITY_W-1:0] expected_quality[$];
    logic clamp_shadow = 1'b0;
    logic quiet = 1'b0;
    logic long_stall_req = 1'b0;
    int in_gap = 0;
    int out_hold = 0;
    int errors = 0;

    always #1 clk = ~clk;

    quad_scaled_jacobian u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .corner0_x (quad_drv[0][0]),
        .corner0_y (quad_drv[0][1]),
        .corner0_z (quad_drv[0][2]),
        .corner1_x (quad_drv[1][0]),
        .corner1_y (quad_drv[1][1]),
        .corner1_z (quad_drv[1][2]),
        .corner2_x (quad_drv[2][0]),
        .corner2_y (quad_drv[2][1]),
        .corner2_z (quad_drv[2][2]),
        .corner3_x (quad_drv[3][0]),
        .corner3_y (quad_drv[3][1]),
        .corner3_z (quad_drv[3][2]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quality   (quality)
    );

    // exact det * 2^14 / sqrt(lu * lv), truncated toward zero
    function automatic longint corner_scaled_jacobian(longint det, longint lu, longint lv);
        logic [127:0] det_sq;
        logic [127:0] len_prod;
        logic [127:0] trial;
        longint mag;
        longint cand;
        if (det == 0 || lu == 0 || lv == 0)
            return 0;
        det_sq = 128'(det < 0 ? -det : det) << RESULT_FRAC_BITS_DEF;
        det_sq = det_sq * det_sq;
        len_prod = 128'(lu) * 128'(lv);
        mag = 0;
        for (int b = RESULT_FRAC_BITS_DEF; b >= 0; b--)
        begin
            cand = mag | (longint'(1) << b);
            trial = 128'(cand * cand) * len_prod;
            if (trial <= det_sq)
                mag = cand;
        end
        return det < 0 ? -mag : mag;
    endfunction

    function automatic logic signed [QUALITY_W-1:0] quad_quality(quad_t q, logic clamp);
        longint u[NUM_AXES];
        longint v[NUM_AXES];
        longint lu;
        longint lv;
        longint det;
        longint val;
        longint worst;
        longint one;
        worst = 0;
        one = longint'(1) << RESULT_FRAC_BITS_DEF;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            lu = 0;
            lv = 0;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                u[k] = longint'($signed(q[EDGE_TAB[c][0]][k]))
                     - longint'($signed(q[EDGE_TAB[c][1]][k]));
                v[k] = longint'($signed(q[EDGE_TAB[c][2]][k]))
                     - longint'($signed(q[EDGE_TAB[c][3]][k]));
                lu += u[k] * u[k];
                lv += v[k] * v[k];
            end
            det = u[0] * v[1] - v[0] * u[1];
            val = corner_scaled_jacobian(det, lu, lv);
            if (c == 0 || val < worst)
                worst = val;
        end
        if (clamp)
        begin
            if (worst > one)
                worst = one;
            if (worst < -one)
                worst = -one;
        end
        if (worst > 32767)
            worst = 32767;
        if (worst < -32768)
            worst = -32768;
        return QUALITY_W'(worst);
    endfunction

    function automatic quad_t make_quad(int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3, int z);
        quad_t q;
        q[0] = {16'(x0), 16'(y0), 16'(z)};
        q[1] = {16'(x1), 16'(y1), 16'(z)};
        q[2] = {16'(x2), 16'(y2), 16'(z)};
        q[3] = {16'(x3), 16'(y3), 16'(z)};
        // packed order is [axis 2..0] within a corner, so reorder x,y,z
        for (int c = 0; c < NUM_CORNERS; c++)
            q[c] = {q[c][0], q[c][1], q[c][2]};
        return q;
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        int kind;
        int s;
        int cx;
        int cy;
        int j;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
                for (int k = 0; k < NUM_AXES; k++)
                    q[c][k] = 16'($urandom);
        end
        else if (kind <= 6)
        begin
            s = $urandom_range(1, 12000);
            j = s / 3 + 1;
            cx = $urandom_range(0, 40000) - 20000;
            cy = $urandom_range(0, 40000) - 20000;
            q = make_quad(cx - s, cy - s, cx + s, cy - s, cx + s, cy + s, cx - s, cy + s,
                          $urandom_range(0, 65535));
            for (int c = 0; c < NUM_CORNERS; c++)
                for (int k = 0; k < NUM_AXES; k++)
                    q[c][k] = q[c][k] + 16'($urandom_range(0, 2 * j) - j);
            if ($urandom_range(0, 3) == 0)
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    q[1][k] = 16'(0);
                end
                q = {q[0], q[3], q[2], q[1]};
            end
        end
        else if (kind == 7)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
                for (int k = 0; k < NUM_AXES; k++)
                    q[c][k] = 16'($urandom);
            q[$urandom_range(0, 3)] = q[$urandom_range(0, 3)];
        end
        else if (kind == 8)
        begin
            // points on one line in x-y, z free
            cx = $urandom_range(0, 200) - 100;
            cy = $urandom_range(0, 200) - 100;
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                j = $urandom_range(0, 200) - 100;
                q[c][0] = 16'(j * cx);
                q[c][1] = 16'(j * cy);
                q[c][2] = 16'($urandom);
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
                for (int k = 0; k < NUM_AXES; k++)
                    q[c][k] = 16'($urandom_range(0, 6) - 3);
        end
        return q;
    endfunction

    // input side: driver plus expectation capture on each accepted transfer
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_quality.push_back(quad_quality(quad_drv, clamp_shadow));
        if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_gap <= $urandom_range(0, 7);
                in_valid <= 1'b0;
            end
            else if (pending_quads.size() != 0)
            begin
                quad_drv <= pending_quads.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: result check and receiver stalls
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_quality.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result quality=%0d", quality);
            end
            else
            begin
                logic signed [QUALITY_W-1:0] exp_q;
                exp_q = expected_quality.pop_front();
                if (quality !== exp_q)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("quality mismatch: expected %0d actual %0d", exp_q, quality);
                end
            end
        end
        if (long_stall_req)
        begin
            long_stall_req <= 1'b0;
            out_hold <= 300;
            out_ready <= 1'b0;
        end
        else if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_hold <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic wait_drained();
        while (pending_quads.size() != 0 || in_valid || expected_quality.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_clamp(logic val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        clamp_shadow = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_quads.push_back(random_quad());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_clamp(1'b0);
        pending_quads.push_back('0);
        pending_quads.push_back({12{CMAX}});
        pending_quads.push_back({12{CMIN}});
        pending_quads.push_back(make_quad(0, 0, 100, 0, 100, 100, 0, 100, 5));
        pending_quads.push_back(make_quad(0, 0, 0, 100, 100, 100, 100, 0, 5));
        pending_quads.push_back(make_quad(-32768, -32768, 32767, -32768,
                                          32767, 32767, -32768, 32767, 0));
        pending_quads.push_back(make_quad(-32768, 32767, 32767, 32767,
                                          32767, -32768, -32768, -32768, -32768));
        pending_quads.push_back(make_quad(0, 0, 10, 0, 10, 0, 0, 10, 3));
        pending_quads.push_back(make_quad(0, 0, 10, 10, 20, 20, 30, 30, 0));
        pending_quads.push_back(make_quad(5, 5, 5, 5, 5, 5, 5, 5, 9));
        pending_quads.push_back(make_quad(0, 0, 100, 0, 20, 20, 0, 100, 0));
        pending_quads.push_back(make_quad(0, 0, 1, 0, 1, 1, 0, 1, 32767));
        pending_quads.push_back(make_quad(0, 0, 32767, 0, 32767, 1, 0, 1, 0));
        write_clamp(1'b1);
        push_random(500);
        repeat (40) @(posedge clk);
        long_stall_req <= 1'b1;
        write_clamp(1'b0);
        push_random(500);
        write_clamp(1'b1);
        quiet <= 1'b1;
        push_random(400);
        wait_drained();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
